FILE: hdl/mfsgd_pkg.sv
// Shared types and constants of the factor update block.
`default_nettype none
package mfsgd_pkg;

  localparam int USERS_DEF    = 1024;
  localparam int ITEMS_DEF    = 1024;
  localparam int FEATURES_DEF = 16;
  localparam int DATA_W       = 16;
  localparam int BASE_W       = 24;
  localparam int CFG_IDX_W    = 3;

  localparam logic [2:0] CMD_WR_USER = 3'd0;
  localparam logic [2:0] CMD_WR_ITEM = 3'd1;
  localparam logic [2:0] CMD_TRAIN   = 3'd2;
  localparam logic [2:0] CMD_RD_USER = 3'd3;
  localparam logic [2:0] CMD_RD_ITEM = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR_REG    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXPLAIN_REG   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NOVELTY_REG   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_MODE = 3'd4;

  typedef enum logic [2:0] {
    OP_NOP, OP_WR_USER, OP_WR_ITEM, OP_TRAIN, OP_RD_USER, OP_RD_ITEM
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [BASE_W-1:0] ubase;
    logic [BASE_W-1:0] ibase;
    logic [3:0]        feature;
    logic [15:0]       value;
    logic [15:0]       rating;
    logic [15:0]       expl;
    logic [15:0]       nov;
  } entry_t;

  typedef struct packed {
    logic [15:0] lr;
    logic [15:0] freg;
    logic [15:0] ereg;
    logic [15:0] nreg;
    logic        mode;
  } cfg_t;

endpackage
`default_nettype wire

FILE: hdl/mfsgd_if.sv
// Request and response channel interfaces.
`default_nettype none
interface mfsgd_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [9:0]  user_index;
  logic [9:0]  item_index;
  logic [3:0]  feature_index;
  logic signed [15:0] write_value;
  logic signed [15:0] rating;
  logic signed [15:0] explain_weight;
  logic signed [15:0] novelty_weight;
  modport source(output valid, command, user_index, item_index, feature_index,
                 write_value, rating, explain_weight, novelty_weight, input ready);
  modport sink(input valid, command, user_index, item_index, feature_index,
               write_value, rating, explain_weight, novelty_weight, output ready);
endinterface

interface mfsgd_rsp_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] read_value;
  logic [15:0] abs_error;
  modport source(output valid, read_value, abs_error, input ready);
  modport sink(input valid, read_value, abs_error, output ready);
endinterface
`default_nettype wire

FILE: hdl/mfsgd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mfsgd_ram #(
  parameter int WIDTH = mfsgd_pkg::DATA_W,
  parameter int DEPTH = 16384,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: hdl/mfsgd_front.sv
// Front end: range checks, command decode and a two-entry queue.
`default_nettype none
module mfsgd_front #(
  parameter int USERS    = mfsgd_pkg::USERS_DEF,
  parameter int ITEMS    = mfsgd_pkg::ITEMS_DEF,
  parameter int FEATURES = mfsgd_pkg::FEATURES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  mfsgd_req_if.sink             req,
  output mfsgd_pkg::entry_t     head,
  output logic                  head_valid,
  input  wire logic             pop
);
  mfsgd_pkg::entry_t q [2];
  mfsgd_pkg::entry_t ent;
  logic              wp, rp;
  logic [1:0]        count;
  logic              uok, iok, fok, push;

  assign uok  = 32'(req.user_index) < USERS;
  assign iok  = 32'(req.item_index) < ITEMS;
  assign fok  = 32'(req.feature_index) < FEATURES;
  assign push = req.valid && req.ready;

  always_comb begin
    ent.ubase   = mfsgd_pkg::BASE_W'(32'(req.user_index) * FEATURES);
    ent.ibase   = mfsgd_pkg::BASE_W'(32'(req.item_index) * FEATURES);
    ent.feature = req.feature_index;
    ent.value   = req.write_value;
    ent.rating  = req.rating;
    ent.expl    = req.explain_weight;
    ent.nov     = req.novelty_weight;
    unique case (req.command)
      mfsgd_pkg::CMD_WR_USER: ent.op = (uok && fok) ? mfsgd_pkg::OP_WR_USER : mfsgd_pkg::OP_NOP;
      mfsgd_pkg::CMD_WR_ITEM: ent.op = (iok && fok) ? mfsgd_pkg::OP_WR_ITEM : mfsgd_pkg::OP_NOP;
      mfsgd_pkg::CMD_TRAIN:   ent.op = (uok && iok) ? mfsgd_pkg::OP_TRAIN : mfsgd_pkg::OP_NOP;
      mfsgd_pkg::CMD_RD_USER: ent.op = (uok && fok) ? mfsgd_pkg::OP_RD_USER : mfsgd_pkg::OP_NOP;
      mfsgd_pkg::CMD_RD_ITEM: ent.op = (iok && fok) ? mfsgd_pkg::OP_RD_ITEM : mfsgd_pkg::OP_NOP;
      default:                ent.op = mfsgd_pkg::OP_NOP;
    endcase
  end

  assign req.ready  = count != 2'd2;
  assign head_valid = count != 2'd0;
  assign head       = q[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= ent;
    end
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

FILE: hdl/mfsgd_back.sv
// Back end: factor tables, dot product pass, pipelined update pass, result register.
`default_nettype none
module mfsgd_back #(
  parameter int USERS    = mfsgd_pkg::USERS_DEF,
  parameter int ITEMS    = mfsgd_pkg::ITEMS_DEF,
  parameter int FEATURES = mfsgd_pkg::FEATURES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mfsgd_pkg::cfg_t   cfg,
  input  wire mfsgd_pkg::entry_t head,
  input  wire logic              head_valid,
  output logic                   pop,
  mfsgd_rsp_if.source            rsp
);
  localparam int UD  = USERS * FEATURES;
  localparam int ID  = ITEMS * FEATURES;
  localparam int UAW = (UD > 1) ? $clog2(UD) : 1;
  localparam int IAW = (ID > 1) ? $clog2(ID) : 1;
  localparam int FCW = $clog2(FEATURES + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISPATCH, ST_RDWAIT, ST_DOT, ST_DOTDRAIN, ST_ERR, ST_ES, ST_UPD, ST_UPDRAIN
  } state_t;

  state_t            state;
  mfsgd_pkg::entry_t cur;
  logic [FCW-1:0]    cnt;

  logic                 u_we, i_we;
  logic [UAW-1:0]       u_waddr, u_raddr;
  logic [IAW-1:0]       i_waddr, i_raddr;
  logic [15:0]          u_wdata, i_wdata, u_rdata, i_rdata;
  logic signed [15:0]   uq, vq;
  logic signed [16:0]   dif;

  logic                 out_valid;
  logic signed [15:0]   out_read;
  logic [15:0]          out_abs;

  logic                 dv1, dv2;
  logic signed [31:0]   prod;
  logic signed [47:0]   acc, accr;
  logic signed [39:0]   e, emag;
  logic signed [15:0]   es;
  logic [15:0]          ae;
  logic signed [32:0]   pe, pn;
  logic signed [33:0]   kc;

  logic                 r_v, a_v, b_v, c_v, d_v;
  logic [FCW-1:0]       r_f, a_f, b_f, c_f, d_f;
  logic signed [15:0]   a_u, a_vv, b_u, b_vv, c_u, c_vv, d_u, d_vv;
  logic signed [31:0]   a_m1, a_m2;
  logic signed [32:0]   a_m3, a_m4;
  logic signed [49:0]   a_m5;
  logic                 a_spos, a_sneg;
  logic signed [51:0]   stx, ex, gv36, gu36, gvr, gur;
  logic signed [39:0]   b_gv, b_gu;
  logic [35:0]          c_plo_v, c_plo_u;
  logic signed [36:0]   c_phi_v, c_phi_u;
  logic signed [56:0]   dsv, dsu, dvr, dur;
  logic signed [28:0]   d_dv, d_du;
  logic signed [29:0]   sv, su;
  logic signed [15:0]   newv, newu;

  assign uq  = $signed(u_rdata);
  assign vq  = $signed(i_rdata);
  assign dif = 17'(uq) - 17'(vq);
  assign pop = (state == ST_IDLE) && head_valid && !out_valid;

  // memory port control
  always_comb begin
    if (state == ST_DISPATCH) begin
      u_raddr = UAW'(cur.ubase) + UAW'(cur.feature);
      i_raddr = IAW'(cur.ibase) + IAW'(cur.feature);
    end else begin
      u_raddr = UAW'(cur.ubase) + UAW'(cnt);
      i_raddr = IAW'(cur.ibase) + IAW'(cnt);
    end
    u_we = d_v || (state == ST_DISPATCH && cur.op == mfsgd_pkg::OP_WR_USER);
    i_we = d_v || (state == ST_DISPATCH && cur.op == mfsgd_pkg::OP_WR_ITEM);
    u_waddr = d_v ? UAW'(cur.ubase) + UAW'(d_f) : UAW'(cur.ubase) + UAW'(cur.feature);
    i_waddr = d_v ? IAW'(cur.ibase) + IAW'(d_f) : IAW'(cur.ibase) + IAW'(cur.feature);
    u_wdata = d_v ? newu : cur.value;
    i_wdata = d_v ? newv : cur.value;
  end

  // update datapath
  always_comb begin
    accr = acc + 48'sd2048;
    emag = e[39] ? -e : e;
    stx  = a_spos ? (52'(kc) <<< 12) : (a_sneg ? -(52'(kc) <<< 12) : 52'sd0);
    ex   = cfg.mode ? 52'(a_m5) : 52'sd0;
    gv36 = (((52'(a_m1) <<< 1) - 52'(a_m3)) <<< 12) + ex - stx;
    gu36 = (((52'(a_m2) <<< 1) - 52'(a_m4)) <<< 12) - ex - stx;
    gvr  = gv36 + 52'sd2048;
    gur  = gu36 + 52'sd2048;
    dsv  = (57'(c_phi_v) <<< 20) + $signed(57'(c_plo_v));
    dsu  = (57'(c_phi_u) <<< 20) + $signed(57'(c_plo_u));
    dvr  = dsv + (57'sd1 <<< 27);
    dur  = dsu + (57'sd1 <<< 27);
    sv   = 30'(d_vv) + 30'(d_dv);
    su   = 30'(d_u) + 30'(d_du);
    newv = (sv > 30'sd32767) ? 16'sh7fff : ((sv < -30'sd32768) ? 16'sh8000 : sv[15:0]);
    newu = (su > 30'sd32767) ? 16'sh7fff : ((su < -30'sd32768) ? 16'sh8000 : su[15:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
      dv1       <= 1'b0;
      dv2       <= 1'b0;
      r_v       <= 1'b0;
      a_v       <= 1'b0;
      b_v       <= 1'b0;
      c_v       <= 1'b0;
      d_v       <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      // dot product pipeline
      dv1  <= (state == ST_DOT);
      dv2  <= dv1;
      prod <= uq * vq;
      if (dv2) begin
        acc <= acc + 48'(prod);
      end
      // update pipeline
      r_v <= (state == ST_UPD);
      r_f <= cnt;
      a_v <= r_v;  a_f <= r_f;  a_u <= uq;  a_vv <= vq;
      a_m1 <= es * uq;
      a_m2 <= es * vq;
      a_m3 <= $signed({1'b0, cfg.freg}) * vq;
      a_m4 <= $signed({1'b0, cfg.freg}) * uq;
      a_m5 <= pe * dif;
      a_spos <= dif > 17'sd0;
      a_sneg <= dif < 17'sd0;
      b_v <= a_v;  b_f <= a_f;  b_u <= a_u;  b_vv <= a_vv;
      b_gv <= $signed(gvr[51:12]);
      b_gu <= $signed(gur[51:12]);
      c_v <= b_v;  c_f <= b_f;  c_u <= b_u;  c_vv <= b_vv;
      c_plo_v <= 36'(b_gv[19:0]) * 36'(cfg.lr);
      c_plo_u <= 36'(b_gu[19:0]) * 36'(cfg.lr);
      c_phi_v <= $signed(b_gv[39:20]) * $signed({1'b0, cfg.lr});
      c_phi_u <= $signed(b_gu[39:20]) * $signed({1'b0, cfg.lr});
      d_v <= c_v;  d_f <= c_f;  d_u <= c_u;  d_vv <= c_vv;
      d_dv <= $signed(dvr[56:28]);
      d_du <= $signed(dur[56:28]);

      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            cur   <= head;
            state <= ST_DISPATCH;
          end
        end
        ST_DISPATCH: begin
          unique case (cur.op) inside
            mfsgd_pkg::OP_RD_USER, mfsgd_pkg::OP_RD_ITEM: state <= ST_RDWAIT;
            mfsgd_pkg::OP_TRAIN: begin
              acc   <= '0;
              cnt   <= '0;
              state <= ST_DOT;
            end
            default: begin
              out_valid <= 1'b1;
              out_read  <= '0;
              out_abs   <= '0;
              state     <= ST_IDLE;
            end
          endcase
        end
        ST_RDWAIT: begin
          out_valid <= 1'b1;
          out_read  <= (cur.op == mfsgd_pkg::OP_RD_USER) ? uq : vq;
          out_abs   <= '0;
          state     <= ST_IDLE;
        end
        ST_DOT: begin
          if (cnt == FCW'(FEATURES - 1)) begin
            cnt   <= '0;
            state <= ST_DOTDRAIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DOTDRAIN: begin
          if (!dv1 && !dv2) begin
            state <= ST_ERR;
          end
        end
        ST_ERR: begin
          e     <= 40'($signed(cur.rating)) - 40'($signed(accr[47:12]));
          pe    <= $signed({1'b0, cfg.ereg}) * $signed(cur.expl);
          pn    <= $signed({1'b0, cfg.nreg}) * $signed(cur.nov);
          state <= ST_ES;
        end
        ST_ES: begin
          es <= (e > 40'sd32767) ? 16'sh7fff : ((e < -40'sd32768) ? 16'sh8000 : e[15:0]);
          ae <= (emag > 40'sd65535) ? 16'hffff : emag[15:0];
          kc <= cfg.mode ? 34'(pn) : 34'(pe) + 34'(pn);
          state <= ST_UPD;
        end
        ST_UPD: begin
          if (cnt == FCW'(FEATURES - 1)) begin
            cnt   <= '0;
            state <= ST_UPDRAIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_UPDRAIN: begin
          if (!r_v && !a_v && !b_v && !c_v && !d_v) begin
            out_valid <= 1'b1;
            out_read  <= '0;
            out_abs   <= ae;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.read_value = out_read;
  assign rsp.abs_error  = out_abs;

  mfsgd_ram #(.WIDTH(mfsgd_pkg::DATA_W), .DEPTH(UD)) u_user_ram (
    .clk(clk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
    .raddr(u_raddr), .rdata(u_rdata)
  );

  mfsgd_ram #(.WIDTH(mfsgd_pkg::DATA_W), .DEPTH(ID)) u_item_ram (
    .clk(clk), .we(i_we), .waddr(i_waddr), .wdata(i_wdata),
    .raddr(i_raddr), .rdata(i_rdata)
  );
endmodule
`default_nettype wire

FILE: hdl/mf_sgd_factor_update.sv
// Top level: configuration registers, front end queue and back end engine.
//
// Usage: commands enter on the req channel (valid/ready); one result leaves on
// the rsp channel per command, in order. Write commands store one Q4.12
// factor, read commands return one, train runs a full SGD step on a user row
// and an item row and returns the absolute prediction error.
// The user must load registers through cfg_we/cfg_index/cfg_data only while
// the block idles; the block itself does not enforce this. A write, an
// unknown or an out-of-range command goes from dispatch straight to the result
// register; a read first waits for the registered RAM read data; a train makes
// one pass over the row to form the dot product, then one pipelined
// read-modify-write pass for the update, both limited to one feature per cycle
// by the single read port of each factor RAM.
// Commands are handled one at a time: the next leaves the queue only after the
// previous result has left the output register.
// A two-entry queue takes transfers while the engine works; the result sits
// in an output register, and a stalled receiver holds it and stops the engine
// from starting the next command, after which req backs up.
// Reset (synchronous, active high) restores register defaults and empties the
// queue; factor tables are not cleared and must be written before use.
`default_nettype none
module mf_sgd_factor_update #(
  parameter int USERS    = mfsgd_pkg::USERS_DEF,
  parameter int ITEMS    = mfsgd_pkg::ITEMS_DEF,
  parameter int FEATURES = mfsgd_pkg::FEATURES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [mfsgd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                    cfg_data,
  mfsgd_req_if.sink                           req,
  mfsgd_rsp_if.source                         rsp
);
  mfsgd_pkg::cfg_t   cfg;
  mfsgd_pkg::entry_t head;
  logic              head_valid, pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lr   <= 16'd655;
      cfg.freg <= 16'd410;
      cfg.ereg <= 16'd410;
      cfg.nreg <= 16'd410;
      cfg.mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        mfsgd_pkg::REG_LEARNING_RATE: cfg.lr   <= cfg_data;
        mfsgd_pkg::REG_FACTOR_REG:    cfg.freg <= cfg_data;
        mfsgd_pkg::REG_EXPLAIN_REG:   cfg.ereg <= cfg_data;
        mfsgd_pkg::REG_NOVELTY_REG:   cfg.nreg <= cfg_data;
        mfsgd_pkg::REG_DISTANCE_MODE: cfg.mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  mfsgd_front #(.USERS(USERS), .ITEMS(ITEMS), .FEATURES(FEATURES)) u_front (
    .clk(clk), .rst(rst), .req(req), .head(head), .head_valid(head_valid), .pop(pop)
  );

  mfsgd_back #(.USERS(USERS), .ITEMS(ITEMS), .FEATURES(FEATURES)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .head(head), .head_valid(head_valid),
    .pop(pop), .rsp(rsp)
  );
endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// Testbench for the SGD factor update block: directed and random traffic checked against a built-in predictor.
module tb;
  import mfsgd_pkg::*;

  localparam int NF = FEATURES_DEF;
  localparam int WD_LIMIT = 20000;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  mfsgd_req_if req();
  mfsgd_rsp_if rsp();

  mf_sgd_factor_update u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req), .rsp(rsp)
  );

  typedef struct packed {
    logic [2:0] command;
    logic [9:0] user_index;
    logic [9:0] item_index;
    logic [3:0] feature_index;
    logic [15:0] write_value;
    logic [15:0] rating;
    logic [15:0] explain_weight;
    logic [15:0] novelty_weight;
  } cmd_t;

  typedef struct packed {
    logic [15:0] read_value;
    logic [15:0] abs_error;
  } res_t;

  cmd_t pending_cmds[$];
  res_t expected_res[$];

  logic [15:0] m_lr = 655, m_freg = 410, m_ereg = 410, m_nreg = 410;
  logic m_mode = 0;
  logic signed [15:0] user_tab [int];
  logic signed [15:0] item_tab [int];

  int errors = 0;
  int n_sent = 0, n_recv = 0, n_train = 0;
  int idle_cycles = 0;
  bit hold_rsp = 0;
  bit stall_pat = 0;
  int burst_left = 0, gap_left = 0;

  initial forever #10 clk = ~clk;

  function automatic longint rnd_shift(longint x, int n);
    longint y;
    y = x + (longint'(1) <<< (n - 1));
    return y >>> n;
  endfunction

  function automatic longint clamp16(longint x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  function automatic longint step_value(longint old, longint g36);
    longint g24;
    g24 = rnd_shift(g36, 12);
    return clamp16(old + rnd_shift(g24 * longint'(m_lr), 28));
  endfunction

  // predictor: apply one command to the shadow tables and return its result
  function automatic res_t predict(cmd_t c);
    res_t r;
    longint acc, e, es, mag, u, v, d, s, gv, gu, ex, nv, t;
    longint fr, er, nr, ew, nw;
    int ub, ib;
    r = '0;
    ub = c.user_index * NF;
    ib = c.item_index * NF;
    case (c.command)
      CMD_WR_USER: user_tab[ub + c.feature_index] = c.write_value;
      CMD_WR_ITEM: item_tab[ib + c.feature_index] = c.write_value;
      CMD_RD_USER: r.read_value = user_tab[ub + c.feature_index];
      CMD_RD_ITEM: r.read_value = item_tab[ib + c.feature_index];
      CMD_TRAIN: begin
        acc = 0;
        for (int f = 0; f < NF; f++)
          acc += longint'(user_tab[ub + f]) * longint'(item_tab[ib + f]);
        e = longint'($signed(c.rating)) - rnd_shift(acc, 12);
        mag = e < 0 ? -e : e;
        r.abs_error = mag > 65535 ? 16'hFFFF : mag[15:0];
        es = clamp16(e);
        fr = m_freg; er = m_ereg; nr = m_nreg;
        ew = $signed(c.explain_weight);
        nw = $signed(c.novelty_weight);
        for (int f = 0; f < NF; f++) begin
          u = user_tab[ub + f];
          v = item_tab[ib + f];
          d = u - v;
          s = (d > 0) ? 1 : ((d < 0) ? -1 : 0);
          gv = (2 * es * u - fr * v) * 4096;
          gu = (2 * es * v - fr * u) * 4096;
          if (m_mode) begin
            ex = er * d * ew;
            nv = s * nr * nw * 4096;
            gv = gv + ex - nv;
            gu = gu - ex - nv;
          end else begin
            t = s * (er * ew + nr * nw) * 4096;
            gv -= t;
            gu -= t;
          end
          item_tab[ib + f] = step_value(v, gv);
          user_tab[ub + f] = step_value(u, gu);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 0;
    end else begin
      if (req.valid && req.ready) begin
        expected_res.push_back(predict(cmd_t'({req.command, req.user_index, req.item_index,
          req.feature_index, req.write_value, req.rating, req.explain_weight,
          req.novelty_weight})));
        n_sent++;
      end
      if (!req.valid || req.ready) begin
        if (pending_cmds.size() == 0 || gap_left > 0) begin
          req.valid <= 0;
          if (gap_left > 0) gap_left--;
        end else begin
          cmd_t c;
          c = pending_cmds.pop_front();
          req.valid <= 1;
          req.command <= c.command;
          req.user_index <= c.user_index;
          req.item_index <= c.item_index;
          req.feature_index <= c.feature_index;
          req.write_value <= c.write_value;
          req.rating <= c.rating;
          req.explain_weight <= c.explain_weight;
          req.novelty_weight <= c.novelty_weight;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_res.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          res_t x;
          x = expected_res.pop_front();
          if (rsp.read_value !== x.read_value) begin
            $error("read_value expected %h actual %h", x.read_value, rsp.read_value);
            errors++;
          end
          if (rsp.abs_error !== x.abs_error) begin
            $error("abs_error expected %h actual %h", x.abs_error, rsp.abs_error);
            errors++;
          end
        end
        n_recv++;
      end
      if ($urandom_range(0, 15) == 0) stall_pat = ~stall_pat;
      rsp.ready <= !hold_rsp && (stall_pat ? ($urandom_range(0, 3) == 0) : 1'b1);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WD_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  int wr_users[$], wr_items[$];

  function automatic cmd_t mk(logic [2:0] op, int ui, int ii, int fi, logic [15:0] val);
    cmd_t c;
    c.command = op;
    c.user_index = ui;
    c.item_index = ii;
    c.feature_index = fi;
    c.write_value = val;
    c.rating = $urandom;
    c.explain_weight = $urandom;
    c.novelty_weight = $urandom;
    return c;
  endfunction

  // load whole rows so training never touches unwritten entries
  task automatic load_rows(int ui, int ii);
    for (int f = 0; f < NF; f++) begin
      pending_cmds.push_back(mk(CMD_WR_USER, ui, ii, f, $urandom));
      pending_cmds.push_back(mk(CMD_WR_ITEM, ui, ii, f, $urandom));
    end
    wr_users.push_back(ui);
    wr_items.push_back(ii);
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || expected_res.size() != 0 || req.valid)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_cfg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      REG_LEARNING_RATE: m_lr = val;
      REG_FACTOR_REG:    m_freg = val;
      REG_EXPLAIN_REG:   m_ereg = val;
      REG_NOVELTY_REG:   m_nreg = val;
      REG_DISTANCE_MODE: m_mode = val[0];
      default: ;
    endcase
  endtask

  task automatic random_phase(int n);
    int k, ui, ii;
    cmd_t c;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 19);
      ui = wr_users[$urandom_range(0, wr_users.size() - 1)];
      ii = wr_items[$urandom_range(0, wr_items.size() - 1)];
      if (k < 8) c = mk(CMD_TRAIN, ui, ii, 0, $urandom);
      else if (k < 10) c = mk(CMD_WR_USER, ui, ii, $urandom_range(0, 15), $urandom);
      else if (k < 12) c = mk(CMD_WR_ITEM, ui, ii, $urandom_range(0, 15), $urandom);
      else if (k < 15) c = mk(CMD_RD_USER, ui, ii, $urandom_range(0, 15), 0);
      else if (k < 18) c = mk(CMD_RD_ITEM, ui, ii, $urandom_range(0, 15), 0);
      else begin
        c = mk($urandom_range(5, 7), $urandom, $urandom, $urandom, $urandom);
      end
      if (c.command == CMD_TRAIN) begin
        // keep ratings mostly moderate, with occasional extremes
        if ($urandom_range(0, 3) != 0) c.rating = $signed($urandom_range(0, 16384)) - 8192;
      end
      pending_cmds.push_back(c);
    end
  endtask

  initial begin
    cmd_t c;
    req.valid = 0;
    req.command = 0; req.user_index = 0; req.item_index = 0; req.feature_index = 0;
    req.write_value = 0; req.rating = 0; req.explain_weight = 0; req.novelty_weight = 0;
    rsp.ready = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extreme rows and values, every command, unknown commands
    load_rows(0, 1023);
    load_rows(1023, 0);
    pending_cmds.push_back(mk(CMD_WR_USER, 0, 0, 15, 16'h7FFF));
    pending_cmds.push_back(mk(CMD_WR_ITEM, 0, 1023, 15, 16'h8000));
    pending_cmds.push_back(mk(CMD_RD_USER, 0, 0, 15, 0));
    pending_cmds.push_back(mk(CMD_RD_ITEM, 0, 1023, 15, 0));
    c = mk(CMD_TRAIN, 0, 1023, 0, 0);
    c.rating = 16'h7FFF; c.explain_weight = 16'h7FFF; c.novelty_weight = 16'h8000;
    pending_cmds.push_back(c);
    c = mk(CMD_TRAIN, 1023, 0, 0, 0);
    c.rating = 16'h8000; c.explain_weight = 16'h8000; c.novelty_weight = 16'h7FFF;
    pending_cmds.push_back(c);
    pending_cmds.push_back(mk(3'd5, 1023, 1023, 15, 16'hFFFF));
    pending_cmds.push_back(mk(3'd7, 0, 0, 0, 0));
    for (int i = 0; i < 2; i++) load_rows($urandom_range(1, 1022), $urandom_range(1, 1022));
    drain();

    // long receiver hold-off with the sender still offering
    random_phase(40);
    hold_rsp = 1;
    repeat (400) @(posedge clk);
    hold_rsp = 0;
    random_phase(150);
    drain();

    set_cfg(REG_DISTANCE_MODE, 1);
    set_cfg(REG_LEARNING_RATE, 16'hFFFF);
    set_cfg(REG_FACTOR_REG, 0);
    set_cfg(REG_EXPLAIN_REG, 16'hFFFF);
    set_cfg(REG_NOVELTY_REG, 0);
    random_phase(100);
    drain();

    set_cfg(REG_DISTANCE_MODE, 0);
    set_cfg(REG_LEARNING_RATE, 0);
    set_cfg(REG_FACTOR_REG, 16'hFFFF);
    set_cfg(REG_EXPLAIN_REG, 0);
    set_cfg(REG_NOVELTY_REG, 16'hFFFF);
    random_phase(80);
    drain();

    for (int p = 0; p < 2; p++) begin
      set_cfg(REG_DISTANCE_MODE, p);
      set_cfg(REG_LEARNING_RATE, $urandom);
      set_cfg(REG_FACTOR_REG, $urandom);
      set_cfg(REG_EXPLAIN_REG, $urandom);
      set_cfg(REG_NOVELTY_REG, $urandom);
      load_rows($urandom_range(0, 1023), $urandom_range(0, 1023));
      random_phase(120);
      drain();
    end

    $display("Run covered %0d commands and %0d results over both regularizer forms,",
             n_sent, n_recv);
    $display("extreme and random register settings, and a long receiver stall.");
    if (errors == 0 && expected_res.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

FILE: files.f
hdl/mfsgd_pkg.sv
hdl/mfsgd_if.sv
hdl/mfsgd_ram.sv
hdl/mfsgd_front.sv
hdl/mfsgd_back.sv
hdl/mf_sgd_factor_update.sv
tb/sv/tb.sv
